// ===== rtl/core/pcfa_pkg.sv =====
// Package with the request, result and storage row types of the contact force accumulator.
`timescale 1ns / 1ps
`default_nettype none
package pcfa_pkg;

  localparam int unsigned DefaultMaxParticles = 1024;
  localparam int unsigned DefaultDimensions   = 3;
  localparam logic [31:0] GainReset           = 32'h0001_0000;

  typedef enum logic [1:0] {
    KIND_LOAD_RADIUS = 2'd0,
    KIND_PAIR_FORCE  = 2'd1,
    KIND_READ_FORCE  = 2'd2,
    KIND_UNUSED      = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_READ      = 2'd0,
    ST_ZERO_DIST = 2'd1,
    ST_READ_SAT  = 2'd2,
    ST_UNUSED    = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic [9:0]         particle_a;
    logic [9:0]         particle_b;
    logic signed [31:0] disp_x;
    logic signed [31:0] disp_y;
    logic signed [31:0] disp_z;
    logic [30:0]        pair_distance;
    logic [30:0]        radius_value;
  } req_t;

  typedef struct packed {
    logic [9:0]         which_particle;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic [1:0]         status;
  } rsp_t;

  typedef struct packed {
    logic             mark;
    logic [2:0][31:0] frc;
  } row_t;

endpackage
`default_nettype wire

// ===== rtl/core/pair_contact_force_accumulator_unit.sv =====
// Top level of the pair contact force accumulator with its sequencer and shared units.
`timescale 1ns / 1ps
`default_nettype none
// The block keeps a radius and a force vector per particle. A request is taken at a
// rising edge with start_i high and busy_o low. Kind 0 stores a radius. Kind 1
// applies a linear spring force to a pair; its work is done by the restoring divider,
// which forms one quotient bit a cycle over 48 bits for each unit vector component,
// and by the shared multiplier, the force row memory port and the read-modify-write
// of both rows. Kind 2 reports a particle's force and clears it; the row is read in
// S_RD_WAIT and S_RD_OUT, and the result is registered from it. A zero distance error
// or a read beyond the particle range gives its result in the cycle after the request.
// Each result is on rsp_o for one cycle with done_o high; the receiver cannot stall,
// and busy_o is low whenever done_o is high. The gain register is written through
// gain_we_i and gain_wdata_i; the user must write it only while the block is idle,
// which the block itself does not enforce. After reset the block clears the force
// memory, one row a cycle, with busy_o high; gain writes are taken meanwhile.
module pair_contact_force_accumulator_unit
  import pcfa_pkg::*;
#(
  parameter int unsigned MAX_PARTICLES = DefaultMaxParticles,
  parameter int unsigned DIMENSIONS    = DefaultDimensions
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire req_t        req_i,
  output logic             busy_o,
  output logic             done_o,
  output rsp_t             rsp_o,
  input  wire logic        gain_we_i,
  input  wire logic [31:0] gain_wdata_i
);

  localparam int unsigned IdxW     = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int unsigned DivSteps = 48;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_RAD_A, S_RAD_B, S_OVL, S_MAG, S_MAG_SAT, S_DIV, S_DIV_SAT,
    S_DLT_MUL, S_DLT_SAT, S_FA_RD, S_FA_WR, S_FB_RD, S_FB_WR, S_RD_WAIT, S_RD_OUT
  } state_e;

  state_e                  state_q;
  req_t                    req_q;
  rsp_t                    rsp_q;
  logic                    done_q;
  logic [31:0]             gain_q;
  logic [IdxW-1:0]         clr_cnt_q;
  logic [30:0]             ra_q;
  logic                    ov_neg_q;
  logic [32:0]             ov_abs_q;
  logic [64:0]             mul_q;
  logic [31:0]             mag_abs_q;
  logic                    mag_neg_q;
  logic                    sat_pair_q;
  logic [1:0]              dim_q;
  logic [5:0]              div_cnt_q;
  logic [30:0]             div_rem_q;
  logic [47:0]             div_dvd_q;
  logic [2:0][31:0]        unit_abs_q;
  logic [2:0]              unit_neg_q;
  logic [2:0][47:0]        delta_q;

  logic [30:0]             radius_mem [MAX_PARTICLES];
  logic [30:0]             rad_rdata_q;
  row_t                    force_mem [MAX_PARTICLES];
  row_t                    row_rdata_q;

  logic                    accept;
  logic                    a_in_range;
  logic                    b_in_range;
  logic                    q_a_in_range;
  logic [IdxW-1:0]         idx_a;
  logic [IdxW-1:0]         idx_b;
  logic                    rad_we;
  logic [IdxW-1:0]         rad_raddr;
  logic [IdxW-1:0]         row_raddr;
  logic                    row_we;
  logic [IdxW-1:0]         row_waddr;
  row_t                    row_wdata;
  logic signed [33:0]      ov_sum;
  logic [32:0]             mul_a;
  logic [31:0]             mul_b;
  logic [64:0]             mul_p;
  logic [48:0]             mag_prod;
  logic [31:0]             mag_abs_d;
  logic                    mag_sat;
  logic signed [31:0]      disp_sel;
  logic                    disp_neg;
  logic [31:0]             div_shift;
  logic                    div_ge;
  logic [31:0]             div_diff;
  logic [31:0]             unit_abs_d;
  logic                    unit_sat;
  logic [46:0]             dlt_abs;
  logic [47:0]             dlt_d;
  row_t                    row_upd;
  logic                    row_sat;
  logic                    last_dim;

  assign accept       = start_i && !busy_o;
  assign a_in_range   = 32'(req_i.particle_a) < MAX_PARTICLES;
  assign b_in_range   = 32'(req_i.particle_b) < MAX_PARTICLES;
  assign q_a_in_range = 32'(req_q.particle_a) < MAX_PARTICLES;
  assign idx_a        = IdxW'(req_q.particle_a);
  assign idx_b        = IdxW'(req_q.particle_b);
  assign rad_we       = accept && (req_i.kind == KIND_LOAD_RADIUS) && a_in_range;
  assign rad_raddr    = (state_q == S_RAD_B) ? idx_b : idx_a;
  assign row_raddr    = (state_q == S_FB_RD) ? idx_b : idx_a;
  assign last_dim     = dim_q == 2'(DIMENSIONS - 1);

  assign ov_sum = $signed({3'b000, ra_q}) + $signed({3'b000, rad_rdata_q})
                - $signed({3'b000, req_q.pair_distance});

  always_comb begin
    if (state_q == S_MAG) begin
      mul_a = ov_abs_q;
      mul_b = gain_q;
    end else begin
      mul_a = {1'b0, mag_abs_q};
      mul_b = unit_abs_q[dim_q];
    end
    mul_p = 65'(mul_a) * 65'(mul_b);
  end

  always_comb begin
    mag_prod = mul_q[64:16];
    mag_sat  = 1'b0;
    mag_abs_d = mag_prod[31:0];
    if (ov_neg_q && (mag_prod > 49'h0_8000_0000)) begin
      mag_sat   = 1'b1;
      mag_abs_d = 32'h8000_0000;
    end else if (!ov_neg_q && (mag_prod > 49'h0_7FFF_FFFF)) begin
      mag_sat   = 1'b1;
      mag_abs_d = 32'h7FFF_FFFF;
    end
  end

  always_comb begin
    unique case (dim_q)
      2'd0:    disp_sel = req_q.disp_x;
      2'd1:    disp_sel = req_q.disp_y;
      default: disp_sel = req_q.disp_z;
    endcase
    disp_neg  = disp_sel[31];
    div_shift = {div_rem_q, div_dvd_q[47]};
    div_ge    = div_shift >= {1'b0, req_q.pair_distance};
    div_diff  = div_ge ? (div_shift - {1'b0, req_q.pair_distance}) : div_shift;
    unit_sat  = 1'b0;
    unit_abs_d = div_dvd_q[31:0];
    if (disp_neg && (div_dvd_q > 48'h0000_8000_0000)) begin
      unit_sat   = 1'b1;
      unit_abs_d = 32'h8000_0000;
    end else if (!disp_neg && (div_dvd_q > 48'h0000_7FFF_FFFF)) begin
      unit_sat   = 1'b1;
      unit_abs_d = 32'h7FFF_FFFF;
    end
  end

  always_comb begin
    dlt_abs = mul_q[62:16];
    dlt_d   = (mag_neg_q ^ unit_neg_q[dim_q]) ? (48'd0 - {1'b0, dlt_abs}) : {1'b0, dlt_abs};
  end

  always_comb begin
    logic signed [48:0] sum;
    row_sat = 1'b0;
    row_upd = row_rdata_q;
    for (int d = 0; d < 3; d++) begin
      if (state_q == S_FA_WR) begin
        sum = 49'($signed(row_rdata_q.frc[d])) + 49'($signed(delta_q[d]));
      end else begin
        sum = 49'($signed(row_rdata_q.frc[d])) - 49'($signed(delta_q[d]));
      end
      if (sum > 49'sh0_7FFF_FFFF) begin
        row_sat        = 1'b1;
        row_upd.frc[d] = 32'h7FFF_FFFF;
      end else if (sum < -49'sh0_8000_0000) begin
        row_sat        = 1'b1;
        row_upd.frc[d] = 32'h8000_0000;
      end else begin
        row_upd.frc[d] = sum[31:0];
      end
    end
    row_upd.mark = row_rdata_q.mark | row_sat | sat_pair_q;
  end

  always_comb begin
    row_we    = 1'b0;
    row_waddr = idx_a;
    row_wdata = '0;
    unique case (state_q)
      S_CLEAR: begin
        row_we    = 1'b1;
        row_waddr = clr_cnt_q;
      end
      S_FA_WR: begin
        row_we    = 1'b1;
        row_wdata = row_upd;
      end
      S_FB_WR: begin
        row_we    = 1'b1;
        row_waddr = idx_b;
        row_wdata = row_upd;
      end
      S_RD_OUT: begin
        row_we = 1'b1;
      end
      default: begin
        row_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rad_we) begin
      radius_mem[IdxW'(req_i.particle_a)] <= req_i.radius_value;
    end
    rad_rdata_q <= radius_mem[rad_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (row_we) begin
      force_mem[row_waddr] <= row_wdata;
    end
    row_rdata_q <= force_mem[row_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GainReset;
    end else if (gain_we_i) begin
      gain_q <= gain_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_p;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      done_q    <= 1'b0;
      clr_cnt_q <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + 1'b1;
          if (clr_cnt_q == IdxW'(MAX_PARTICLES - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            req_q <= req_i;
            rsp_q <= '{which_particle: req_i.particle_a,
                       force_x: '0,
                       force_y: '0,
                       force_z: '0,
                       status: ((req_i.kind == KIND_PAIR_FORCE) &&
                                (req_i.pair_distance == '0)) ? ST_ZERO_DIST : ST_READ};
            case (req_i.kind)
              KIND_PAIR_FORCE: begin
                if (a_in_range && b_in_range) begin
                  if (req_i.pair_distance == '0) begin
                    done_q <= 1'b1;
                  end else begin
                    state_q <= S_RAD_A;
                  end
                end
              end
              KIND_READ_FORCE: begin
                if (a_in_range) begin
                  state_q <= S_RD_WAIT;
                end else begin
                  done_q <= 1'b1;
                end
              end
              default: begin
                state_q <= S_IDLE;
              end
            endcase
          end
        end
        S_RAD_A: state_q <= S_RAD_B;
        S_RAD_B: begin
          ra_q    <= rad_rdata_q;
          state_q <= S_OVL;
        end
        S_OVL: begin
          ov_neg_q   <= ov_sum[33];
          ov_abs_q   <= ov_sum[33] ? 33'(-ov_sum) : ov_sum[32:0];
          delta_q[2] <= '0;
          state_q    <= S_MAG;
        end
        S_MAG: state_q <= S_MAG_SAT;
        S_MAG_SAT: begin
          mag_abs_q  <= mag_abs_d;
          mag_neg_q  <= ov_neg_q;
          sat_pair_q <= mag_sat;
          dim_q      <= '0;
          div_cnt_q  <= 6'(DivSteps - 1);
          div_rem_q  <= '0;
          div_dvd_q  <= {req_q.disp_x[31] ? (32'd0 - 32'(req_q.disp_x)) : 32'(req_q.disp_x),
                         16'h0000};
          state_q    <= S_DIV;
        end
        S_DIV: begin
          div_rem_q <= div_diff[30:0];
          div_dvd_q <= {div_dvd_q[46:0], div_ge};
          div_cnt_q <= div_cnt_q - 1'b1;
          if (div_cnt_q == '0) begin
            state_q <= S_DIV_SAT;
          end
        end
        S_DIV_SAT: begin
          unit_abs_q[dim_q] <= unit_abs_d;
          unit_neg_q[dim_q] <= disp_neg;
          if (unit_sat) begin
            sat_pair_q <= 1'b1;
          end
          if (last_dim) begin
            dim_q   <= '0;
            state_q <= S_DLT_MUL;
          end else begin
            dim_q     <= dim_q + 1'b1;
            div_cnt_q <= 6'(DivSteps - 1);
            div_rem_q <= '0;
            div_dvd_q <= {(dim_q == 2'd0) ?
                          (req_q.disp_y[31] ? (32'd0 - 32'(req_q.disp_y)) : 32'(req_q.disp_y)) :
                          (req_q.disp_z[31] ? (32'd0 - 32'(req_q.disp_z)) : 32'(req_q.disp_z)),
                          16'h0000};
            state_q   <= S_DIV;
          end
        end
        S_DLT_MUL: state_q <= S_DLT_SAT;
        S_DLT_SAT: begin
          delta_q[dim_q] <= dlt_d;
          if (last_dim) begin
            state_q <= S_FA_RD;
          end else begin
            dim_q   <= dim_q + 1'b1;
            state_q <= S_DLT_MUL;
          end
        end
        S_FA_RD: state_q <= S_FA_WR;
        S_FA_WR: state_q <= S_FB_RD;
        S_FB_RD: state_q <= S_FB_WR;
        S_FB_WR: state_q <= S_IDLE;
        S_RD_WAIT: state_q <= S_RD_OUT;
        S_RD_OUT: begin
          rsp_q   <= '{which_particle: rsp_q.which_particle,
                       force_x: row_rdata_q.frc[0],
                       force_y: row_rdata_q.frc[1],
                       force_z: row_rdata_q.frc[2],
                       status: row_rdata_q.mark ? ST_READ_SAT : ST_READ};
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o = state_q != S_IDLE;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

`ifndef SYNTH
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("result shown while busy");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rsp_o.status != ST_UNUSED)) else $error("unused status code");

  a_zero_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_i.kind == KIND_PAIR_FORCE) && a_in_range && b_in_range &&
     (req_i.pair_distance == '0)) |=>
    (done_o && (rsp_o.status == ST_ZERO_DIST) && (rsp_o.force_x == '0)))
    else $error("zero distance error missing");

  a_read_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_i.kind == KIND_READ_FORCE) && !a_in_range) |=>
    (done_o && (rsp_o.status == ST_READ))) else $error("out of range read missing");

  a_pair_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_i.kind == KIND_PAIR_FORCE) && (req_i.pair_distance != '0)) |=>
    !done_o) else $error("pair request gave a result");
`endif

endmodule
`default_nettype wire
